/* rtl/sli_pkg.sv */
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and constants for the sorted list insert/delete block.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } sli_op_t;

    typedef enum logic [1:0]
    {
        ST_INSERTED  = 2'd0,
        ST_DELETED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } sli_status_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_INS_RD,
        S_INS_EXE,
        S_DEL_RD,
        S_DEL_EXE,
        S_FST_RD,
        S_FST_EXE,
        S_EMIT
    } sli_state_t;

    typedef struct packed
    {
        sli_op_t            op;
        logic signed [31:0] item_value;
    } sli_in_t;

    typedef struct packed
    {
        sli_status_t        status;
        logic [4:0]         entry_count;
        logic signed [31:0] smallest_value;
        logic signed [31:0] largest_value;
    } sli_out_t;

endpackage

/* rtl/sorted_list_insert_delete.sv */
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Bounded ascending list of signed values with in-order insert and
// first-match delete, reporting count, smallest and largest entry.
// ----------------------------------------------------------------------------
// Insert scans from the tail toward its position, delete scans every held entry,
// and a full insert only reads the first and last entry; output backpressure
// holds the result. The next transaction is taken once the result is loaded.
// One transaction at a time; every entry visited takes a read on the
// single read port of the entry memory (address, then registered data).
// Reset clears the count, the sequencer and the output valid; the entry
// memory is not cleared, only entries below the count are ever read.
module sorted_list_insert_delete #(
    parameter int DEPTH = sli_pkg::DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sli_pkg::sli_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output sli_pkg::sli_out_t out_data
);
    import sli_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(DEPTH);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    sli_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               found_reg, found_next;
    logic signed [31:0] v_reg, v_next;
    sli_status_t        status_reg, status_next;
    logic signed [31:0] min_reg, min_next;
    logic               out_valid_reg, out_valid_next;
    sli_out_t           out_data_reg, out_data_next;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               we;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    logic [CNT_W-1:0]   idx_dec;
    logic [CNT_W-1:0]   cnt_dec;
    logic               full;
    logic               lt;
    logic               load_ok;

    assign idx_dec = idx_reg - 1'b1;
    assign cnt_dec = cnt_reg - 1'b1;
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign lt      = (v_reg < rd_data_reg);
    assign load_ok = !out_valid_reg || out_ready;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.op == OP_DELETE)
                        state_next = S_DEL_RD;
                    else if (full)
                        state_next = S_FST_RD;
                    else
                        state_next = S_INS_RD;
                end
            end
            S_INS_RD:  state_next = (idx_reg == '0) ? S_FST_RD : S_INS_EXE;
            S_INS_EXE: state_next = lt ? S_INS_RD : S_FST_RD;
            S_DEL_RD:  state_next = (idx_reg == cnt_reg) ? S_FST_RD : S_DEL_EXE;
            S_DEL_EXE: state_next = S_DEL_RD;
            S_FST_RD:  state_next = (cnt_reg == '0) ? S_EMIT : S_FST_EXE;
            S_FST_EXE: state_next = S_EMIT;
            S_EMIT:
            begin
                if (load_ok)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        v_next         = v_reg;
        status_next    = status_reg;
        min_next       = min_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        we             = 1'b0;
        wr_addr        = '0;
        wr_data        = v_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    v_next     = in_data.item_value;
                    found_next = 1'b0;
                    if (in_data.op == OP_DELETE)
                    begin
                        idx_next = '0;
                    end
                    else if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        idx_next    = cnt_reg;
                        cnt_next    = cnt_reg + 1'b1;
                        status_next = ST_INSERTED;
                    end
                end
            end
            S_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    we      = 1'b1;
                    wr_addr = '0;
                    wr_data = v_reg;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_dec[AW-1:0];
                end
            end
            S_INS_EXE:
            begin
                we      = 1'b1;
                wr_addr = idx_reg[AW-1:0];
                wr_data = lt ? rd_data_reg : v_reg;
                if (lt)
                    idx_next = idx_dec;
            end
            S_DEL_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    if (found_reg)
                    begin
                        cnt_next    = cnt_dec;
                        status_next = ST_DELETED;
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_reg[AW-1:0];
                end
            end
            S_DEL_EXE:
            begin
                // entries after the match move down by one
                if (found_reg)
                begin
                    we      = 1'b1;
                    wr_addr = idx_dec[AW-1:0];
                    wr_data = rd_data_reg;
                end
                else if (rd_data_reg == v_reg)
                begin
                    found_next = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
            end
            S_FST_RD:
            begin
                if (cnt_reg == '0)
                begin
                    min_next = '0;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                end
            end
            S_FST_EXE:
            begin
                min_next = rd_data_reg;
                rd_en    = 1'b1;
                rd_addr  = cnt_dec[AW-1:0];
            end
            S_EMIT:
            begin
                if (load_ok)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.status         = status_reg;
                    out_data_next.entry_count    = 5'(cnt_reg);
                    out_data_next.smallest_value = min_reg;
                    out_data_next.largest_value  = (cnt_reg == '0) ? '0 : rd_data_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        v_reg        <= v_next;
        status_reg   <= status_next;
        min_reg      <= min_next;
        out_data_reg <= out_data_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == $past(cnt_reg)) ||
        (cnt_reg == CNT_W'($past(cnt_reg) + 1'b1)) ||
        (cnt_reg == CNT_W'($past(cnt_reg) - 1'b1)))
        else $error("entry count moved by more than one");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && status_reg == ST_FULL) |-> full)
        else $error("full status with free entries");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_EMIT) |-> !we)
        else $error("memory write outside an operation");

    a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && load_ok) |=> out_valid)
        else $error("result not presented");

endmodule

/* tb/sorted_list_insert_delete_tb.sv */
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_tb
// Self-checking testbench for the sorted list block. A queue of insert and
// delete operations drives the input channel; a behavioral list model
// predicts status, count, smallest and largest value for each transaction,
// and every result is checked field by field under random backpressure.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sli_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 60;
    localparam int QUIET_LO    = 3000;
    localparam int QUIET_HI    = 9000;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    sli_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    sli_out_t out_data;

    sli_in_t            pending_ops[$];
    sli_out_t           expected_results[$];
    logic signed [31:0] gen_pool[$];

    logic signed [31:0] list_vals[DEPTH];
    int                 list_len = 0;

    int       cycle_cnt = 0;
    int       fail_cnt  = 0;
    bit       in_fire   = 1'b0;
    bit       quiet;
    sli_out_t want;
    int       status_seen[4] = '{default: 0};
    int       peak_count = 0;

    always #2 clk = ~clk;

    sorted_list_insert_delete #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    function automatic sli_out_t apply_list_op(sli_in_t txn);
        sli_out_t res;
        int       pos;
        res = '0;
        if (txn.op == OP_INSERT) begin
            if (list_len >= DEPTH) begin
                res.status = ST_FULL;
            end
            else begin
                pos = list_len;
                for (int i = 0; i < list_len; i++) begin
                    if (txn.item_value < list_vals[i]) begin
                        pos = i;
                        break;
                    end
                end
                for (int i = list_len; i > pos; i--)
                    list_vals[i] = list_vals[i - 1];
                list_vals[pos] = txn.item_value;
                list_len++;
                res.status = ST_INSERTED;
            end
        end
        else begin
            pos = list_len;
            for (int i = 0; i < list_len; i++) begin
                if (list_vals[i] == txn.item_value) begin
                    pos = i;
                    break;
                end
            end
            if (pos < list_len) begin
                for (int i = pos; i + 1 < list_len; i++)
                    list_vals[i] = list_vals[i + 1];
                list_len--;
                res.status = ST_DELETED;
            end
            else begin
                res.status = ST_NOT_FOUND;
            end
        end
        res.entry_count = list_len[4:0];
        if (list_len != 0) begin
            res.smallest_value = list_vals[0];
            res.largest_value  = list_vals[list_len - 1];
        end
        return res;
    endfunction

    // keeps gen_pool in step with the list contents so deletes can target held values
    task automatic queue_op(sli_op_t op, logic signed [31:0] val);
        sli_in_t t;
        t.op         = op;
        t.item_value = val;
        pending_ops.push_back(t);
        if (op == OP_INSERT) begin
            if (gen_pool.size() < DEPTH)
                gen_pool.push_back(val);
        end
        else begin
            for (int i = 0; i < gen_pool.size(); i++) begin
                if (gen_pool[i] == val) begin
                    gen_pool.delete(i);
                    break;
                end
            end
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:          return 32'sh8000_0000;
            1:          return 32'sh7FFF_FFFF;
            2, 3, 4, 5: return int'($urandom_range(0, 8)) - 4;
            default:    return $urandom;
        endcase
    endfunction

    // driver
    always @(negedge clk) begin
        if (rst_n) begin
            quiet = (cycle_cnt >= QUIET_LO) && (cycle_cnt < QUIET_HI);
            if (!in_valid || in_fire) begin
                if (pending_ops.size() != 0 && (quiet || $urandom_range(0, 99) >= 8)) begin
                    in_data  <= pending_ops.pop_front();
                    in_valid <= 1'b1;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= quiet || ($urandom_range(0, 99) >= 8);
        end
    end

    // monitor and checker
    always @(posedge clk) begin
        if (rst_n) begin
            cycle_cnt++;
            in_fire = in_valid && in_ready;
            if (in_fire)
                expected_results.push_back(apply_list_op(in_data));
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction: status %0d count %0d",
                           out_data.status, out_data.entry_count);
                    fail_cnt++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_data.status);
                        fail_cnt++;
                    end
                    if (out_data.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, out_data.entry_count);
                        fail_cnt++;
                    end
                    if (out_data.smallest_value !== want.smallest_value) begin
                        $error("smallest_value: expected %0d, got %0d",
                               want.smallest_value, out_data.smallest_value);
                        fail_cnt++;
                    end
                    if (out_data.largest_value !== want.largest_value) begin
                        $error("largest_value: expected %0d, got %0d",
                               want.largest_value, out_data.largest_value);
                        fail_cnt++;
                    end
                    status_seen[want.status]++;
                    if (want.entry_count > peak_count)
                        peak_count = want.entry_count;
                end
            end
            if (cycle_cnt > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_cnt);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int bias;

        // directed: empty list, extremes, duplicates, misses, fill to full
        queue_op(OP_DELETE, 32'sd0);
        queue_op(OP_INSERT, 32'sh7FFF_FFFF);
        queue_op(OP_DELETE, 32'sh7FFF_FFFF);
        queue_op(OP_INSERT, 32'sh8000_0000);
        queue_op(OP_INSERT, 32'sh7FFF_FFFF);
        queue_op(OP_INSERT, 32'sd0);
        queue_op(OP_INSERT, 32'sd0);
        queue_op(OP_INSERT, -32'sd1);
        queue_op(OP_DELETE, 32'sd5);
        queue_op(OP_DELETE, 32'sh7FFF_FFFF);
        queue_op(OP_DELETE, 32'sh8000_0000);
        for (int k = 0; k < 13; k++)
            queue_op(OP_INSERT, (k[0] ? 32'sh5555_5555 : 32'shAAAA_AAAA) ^ (k * 32'h0101_0101));
        queue_op(OP_INSERT, 32'sd7);

        // random: segments biased toward filling, draining or churning the list
        for (int seg = 0; seg < 45; seg++) begin
            case ($urandom_range(0, 3))
                0:       bias = 15;
                1:       bias = 50;
                2:       bias = 85;
                default: bias = 97;
            endcase
            for (int k = 0; k < 25; k++) begin
                if ($urandom_range(0, 99) < bias)
                    queue_op(OP_INSERT, pick_value());
                else if (gen_pool.size() != 0 && $urandom_range(0, 99) < 80)
                    queue_op(OP_DELETE, gen_pool[$urandom_range(0, gen_pool.size() - 1)]);
                else
                    queue_op(OP_DELETE, pick_value());
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_cnt++;
        end

        $display("Checked %0d transactions in %0d cycles, peak list size %0d of %0d.",
                 status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3],
                 cycle_cnt, peak_count, DEPTH);
        $display("Inserted %0d, deleted %0d, not found %0d, rejected as full %0d.",
                 status_seen[ST_INSERTED], status_seen[ST_DELETED],
                 status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
